// ===== design/mau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int RW = 30;   // residue / modulus width
  localparam int EW = 63;   // exponent width
  localparam int SW = 64;   // signed value width
  localparam int CW = 34;   // Bezout coefficient width, signed

  localparam logic [RW-1:0] MOD_RESET = 30'd1000000007;

  typedef logic [RW-1:0] res_t;
  typedef logic signed [CW-1:0] coef_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INV = 3'd5,
    OP_POW = 3'd6,
    OP_RED = 3'd7
  } op_t;

endpackage

// ===== design/mau_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_reduce
// Bit-serial reduction of a 64-bit unsigned value modulo m, one bit a cycle.
// ----------------------------------------------------------------------------
module mau_reduce (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  mau_pkg::res_t            m,
  input  logic [mau_pkg::SW-1:0]   value,
  output logic                     done,
  output mau_pkg::res_t            r
);
  import mau_pkg::*;

  logic [SW-1:0] sh;
  logic [5:0]    cnt;
  logic          active;
  logic [RW:0]   t;
  logic [RW:0]   t_sub;
  res_t          r_next;

  always_comb begin
    t      = {r, sh[SW-1]};
    t_sub  = t - {1'b0, m};
    r_next = (t >= {1'b0, m}) ? t_sub[RW-1:0] : t[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
        sh     <= value;
        r      <= '0;
      end else if (active) begin
        r   <= r_next;
        sh  <= {sh[SW-2:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/mau_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_modmul
// Interleaved bit-serial modular multiply, multiplier bits MSB first.
// ----------------------------------------------------------------------------
module mau_modmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  mau_pkg::res_t m,
  input  mau_pkg::res_t x,
  input  mau_pkg::res_t y,
  output logic          done,
  output mau_pkg::res_t r
);
  import mau_pkg::*;

  res_t        ysh;
  res_t        xr;
  logic [4:0]  cnt;
  logic        active;
  logic [RW:0] t;
  logic [RW:0] t_sub;
  res_t        t1;
  logic [RW:0] s;
  logic [RW:0] s_sub;
  res_t        r_next;

  always_comb begin
    t      = {r, 1'b0};
    t_sub  = t - {1'b0, m};
    t1     = (t >= {1'b0, m}) ? t_sub[RW-1:0] : t[RW-1:0];
    s      = {1'b0, t1} + (ysh[RW-1] ? {1'b0, xr} : '0);
    s_sub  = s - {1'b0, m};
    r_next = (s >= {1'b0, m}) ? s_sub[RW-1:0] : s[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= '0;
        xr     <= x;
        ysh    <= y;
        r      <= '0;
      end else if (active) begin
        r   <= r_next;
        ysh <= {ysh[RW-2:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(RW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/mau_modinv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_modinv
// Extended Euclid; each quotient step is a bit-serial restoring division
// that builds q*v alongside the remainder.
// ----------------------------------------------------------------------------
module mau_modinv (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  mau_pkg::res_t m,
  input  mau_pkg::res_t x,
  output logic          done,
  output mau_pkg::res_t r
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    I_IDLE = 4'b0001,
    I_DIV  = 4'b0010,
    I_UPD  = 4'b0100,
    I_FIN  = 4'b1000
  } inv_state_t;

  inv_state_t  state;
  res_t        b;
  res_t        sh;
  res_t        rem;
  coef_t       u;
  coef_t       v;
  coef_t       p;
  logic [4:0]  cnt;
  logic [RW:0] t;
  logic [RW:0] t_sub;
  logic        qb;
  coef_t       p_next;
  coef_t       mag;
  coef_t       mag_red;
  coef_t       u_red;
  coef_t       m_ext;
  coef_t       fin_val;

  always_comb begin
    m_ext   = coef_t'({1'b0, m});
    t       = {rem, sh[RW-1]};
    t_sub   = t - {1'b0, b};
    qb      = (t >= {1'b0, b});
    p_next  = (p <<< 1) + (qb ? v : coef_t'(0));
    u_red   = (u >= m_ext) ? u - m_ext : u;
    mag     = -u;
    mag_red = (mag >= m_ext) ? mag - m_ext : mag;
    if (!u[CW-1]) begin
      fin_val = u_red;
    end else if (mag_red == coef_t'(0)) begin
      fin_val = '0;
    end else begin
      fin_val = m_ext - mag_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        I_IDLE: begin
          if (go) begin
            b     <= m;
            u     <= coef_t'(1);
            v     <= '0;
            sh    <= x;
            rem   <= '0;
            p     <= '0;
            cnt   <= '0;
            state <= I_DIV;
          end
        end
        I_DIV: begin
          rem <= qb ? t_sub[RW-1:0] : t[RW-1:0];
          sh  <= {sh[RW-2:0], 1'b0};
          p   <= p_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(RW - 1)) begin
            state <= I_UPD;
          end
        end
        I_UPD: begin
          // shift the pair: (a, b) <- (b, a mod b), (u, v) <- (v, u - q*v)
          b   <= rem;
          u   <= v;
          v   <= u - p;
          sh  <= b;
          rem <= '0;
          p   <= '0;
          cnt <= '0;
          state <= (rem == '0) ? I_FIN : I_DIV;
        end
        I_FIN: begin
          r     <= fin_val[RW-1:0];
          done  <= 1'b1;
          state <= I_IDLE;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

endmodule

// ===== design/modular_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular add/sub/mul/div/neg/inverse/pow/reduce over a configurable modulus.
//
//   channel   signals                                          dir
//   request   start, busy(out), req_type, operand_a, operand_b, in
//             exponent, signed_value
//   result    done, residue                                     out
//   config    cfg_we, cfg_wdata (modulus)                       in
//
// A request is taken when start is high and busy low; done marks the residue
// for one cycle. Operands are first reduced through a bit-serial reducer;
// mul is bit-serial, inverse is extended Euclid, div is inverse of operand_b
// then a multiply, and pow scans the exponent LSB first, multiplying on each
// set bit and squaring on every bit. Synchronous reset sets the modulus to
// 1000000007. The result cannot be stalled.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   req_type,
  input  logic [mau_pkg::RW-1:0]       operand_a,
  input  logic [mau_pkg::RW-1:0]       operand_b,
  input  logic [mau_pkg::EW-1:0]       exponent,
  input  logic signed [mau_pkg::SW-1:0] signed_value,
  input  logic                         cfg_we,
  input  logic [mau_pkg::RW-1:0]       cfg_wdata,
  output logic                         done,
  output logic [mau_pkg::RW-1:0]       residue
);
  import mau_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RED_A = 11'b00000000010,
    S_RED_B = 11'b00000000100,
    S_RED_S = 11'b00000001000,
    S_EXEC  = 11'b00000010000,
    S_INV   = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_POW   = 11'b00010000000,
    S_PMUL  = 11'b00100000000,
    S_PSQR  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t        state;
  res_t          modulus;
  op_t           op;
  logic [EW-1:0] e;
  logic          neg;
  res_t          ob;
  res_t          ra;
  res_t          rb;
  res_t          acc;
  res_t          sq;
  res_t          res;

  logic          red_go, red_done;
  logic [SW-1:0] red_val;
  res_t          red_r;
  logic          mul_go, mul_done;
  res_t          mul_x, mul_y, mul_r;
  logic          inv_go, inv_done;
  res_t          inv_x, inv_r;

  logic [RW:0]   add_s;
  logic [RW:0]   add_sub;
  logic [RW:0]   sub_w;
  res_t          sv_res;
  logic [SW-1:0] sv_mag;

  assign busy    = (state != S_IDLE);
  assign done    = (state == S_OUT);
  assign residue = res;

  always_comb begin
    add_s   = {1'b0, ra} + {1'b0, rb};
    add_sub = add_s - {1'b0, modulus};
    sub_w   = {1'b0, ra} + {1'b0, modulus} - {1'b0, rb};
    sv_res  = (red_r == '0) ? '0 : modulus - red_r;
    sv_mag  = signed_value[SW-1] ? (~signed_value + 64'd1) : signed_value;
  end

  mau_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .go    (red_go),
    .m     (modulus),
    .value (red_val),
    .done  (red_done),
    .r     (red_r)
  );

  mau_modmul u_modmul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .m    (modulus),
    .x    (mul_x),
    .y    (mul_y),
    .done (mul_done),
    .r    (mul_r)
  );

  mau_modinv u_modinv (
    .clk  (clk),
    .rst  (rst),
    .go   (inv_go),
    .m    (modulus),
    .x    (inv_x),
    .done (inv_done),
    .r    (inv_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      red_go <= 1'b0;
      mul_go <= 1'b0;
      inv_go <= 1'b0;
    end else begin
      red_go <= 1'b0;
      mul_go <= 1'b0;
      inv_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op  <= op_t'(req_type);
            e   <= exponent;
            neg <= signed_value[SW-1];
            ob  <= operand_b;
            if (modulus < 30'd2) begin
              res   <= '0;
              state <= S_OUT;
            end else if (op_t'(req_type) == OP_RED) begin
              red_val <= sv_mag;
              red_go  <= 1'b1;
              state   <= S_RED_S;
            end else begin
              red_val <= {{(SW-RW){1'b0}}, operand_a};
              red_go  <= 1'b1;
              state   <= S_RED_A;
            end
          end
        end
        S_RED_A: begin
          if (red_done) begin
            ra      <= red_r;
            red_val <= {{(SW-RW){1'b0}}, ob};
            red_go  <= 1'b1;
            state   <= S_RED_B;
          end
        end
        S_RED_B: begin
          if (red_done) begin
            rb    <= red_r;
            state <= S_EXEC;
          end
        end
        S_RED_S: begin
          if (red_done) begin
            res   <= neg ? sv_res : red_r;
            state <= S_OUT;
          end
        end
        S_EXEC: begin
          unique case (op)
            OP_ADD: begin
              res   <= (add_s >= {1'b0, modulus}) ? add_sub[RW-1:0] : add_s[RW-1:0];
              state <= S_OUT;
            end
            OP_SUB: begin
              res   <= (ra >= rb) ? ra - rb : sub_w[RW-1:0];
              state <= S_OUT;
            end
            OP_NEG: begin
              res   <= (ra == '0) ? '0 : modulus - ra;
              state <= S_OUT;
            end
            OP_MUL: begin
              mul_x  <= ra;
              mul_y  <= rb;
              mul_go <= 1'b1;
              state  <= S_MUL;
            end
            OP_DIV: begin
              inv_x  <= rb;
              inv_go <= 1'b1;
              state  <= S_INV;
            end
            OP_INV: begin
              inv_x  <= ra;
              inv_go <= 1'b1;
              state  <= S_INV;
            end
            OP_POW: begin
              acc   <= res_t'(1);
              sq    <= ra;
              state <= S_POW;
            end
            OP_RED: begin
              res   <= '0;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_INV: begin
          if (inv_done) begin
            if (op == OP_DIV) begin
              mul_x  <= ra;
              mul_y  <= inv_r;
              mul_go <= 1'b1;
              state  <= S_MUL;
            end else begin
              res   <= inv_r;
              state <= S_OUT;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            res   <= mul_r;
            state <= S_OUT;
          end
        end
        S_POW: begin
          // consume exponent bits LSB first
          if (e == '0) begin
            res   <= acc;
            state <= S_OUT;
          end else if (e[0]) begin
            mul_x  <= acc;
            mul_y  <= sq;
            mul_go <= 1'b1;
            state  <= S_PMUL;
          end else begin
            mul_x  <= sq;
            mul_y  <= sq;
            mul_go <= 1'b1;
            state  <= S_PSQR;
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            acc    <= mul_r;
            mul_x  <= sq;
            mul_y  <= sq;
            mul_go <= 1'b1;
            state  <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (mul_done) begin
            sq    <= mul_r;
            e     <= {1'b0, e[EW-1:1]};
            state <= S_POW;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
